// ----- sv/s2c_pkg.sv -----
`default_nettype none
package s2c_pkg;

  localparam int ANG_W = 16;
  localparam int SCL_W = 16;
  localparam int RAD_W = 16;
  localparam int OUT_W = 27;
  localparam int CW    = 32;
  localparam int S2C_STAGES = 16;
  localparam int ATAN_DEPTH = 24;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd1000;
  localparam logic signed [34:0] PHASE_MUL = 35'sd10937044409;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [CW-1:0] HALF_QUAD = 32'h2000_0000;

  localparam logic [CW-1:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic             vld;
    quad_t            qa;
    quad_t            qp;
    logic [SCL_W-1:0] scale;
    rot_t             ra;
    rot_t             rp;
  } beat_t;

  function automatic logic [CW-1:0] atan_phase(input int i);
    logic [CW-1:0] t;
    t = '0;
    if (i >= 0 && i < ATAN_DEPTH) begin
      t = ATAN_TAB[i[4:0]];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- sv/s2c_phase.sv -----
`default_nettype none
module s2c_phase (
  input  logic                               clk,
  input  logic signed [s2c_pkg::ANG_W-1:0]   angle,
  output s2c_pkg::quad_t                     quad,
  output logic signed [s2c_pkg::CW-1:0]      resid
);
  import s2c_pkg::*;

  logic signed [50:0] prod;
  logic [CW-1:0]      phase;
  logic [CW-1:0]      phase_rnd;
  quad_t              quad_nxt;
  logic [CW-1:0]      resid_nxt;
  quad_t              quad_r;
  logic [CW-1:0]      resid_r;

  assign prod      = angle * PHASE_MUL;
  assign phase     = prod[47:16];
  assign phase_rnd = phase + HALF_QUAD;
  assign quad_nxt  = quad_t'(phase_rnd[CW-1:CW-2]);
  assign resid_nxt = phase - {phase_rnd[CW-1:CW-2], {(CW-2){1'b0}}};

  always_ff @(posedge clk) begin
    quad_r  <= quad_nxt;
    resid_r <= resid_nxt;
  end

  assign quad  = quad_r;
  assign resid = $signed(resid_r);

endmodule
`default_nettype wire

// ----- sv/s2c_cell.sv -----
`default_nettype none
module s2c_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  s2c_pkg::beat_t beat_in,
  output s2c_pkg::beat_t beat_out
);
  import s2c_pkg::*;

  localparam logic [CW-1:0] ANG = atan_phase(STAGE);

  function automatic rot_t rotate(input rot_t v);
    rot_t                 o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = $signed(v.y) >>> STAGE;
    dy = $signed(v.x) >>> STAGE;
    if (!v.z[CW-1]) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - $signed(ANG);
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + $signed(ANG);
    end
    return o;
  endfunction

  logic  vld_r;
  beat_t pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= beat_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    pay_r.vld   <= 1'b0;
    pay_r.qa    <= beat_in.qa;
    pay_r.qp    <= beat_in.qp;
    pay_r.scale <= beat_in.scale;
    pay_r.ra    <= rotate(beat_in.ra);
    pay_r.rp    <= rotate(beat_in.rp);
  end

  always_comb begin
    beat_out     = pay_r;
    beat_out.vld = vld_r;
  end

endmodule
`default_nettype wire

// ----- sv/s2c_post.sv -----
`default_nettype none
module s2c_post (
  input  logic                               clk,
  input  logic                               rst_n,
  input  s2c_pkg::beat_t                     beat_in,
  input  logic [s2c_pkg::RAD_W-1:0]          radius,
  output logic                               strobe,
  output logic signed [s2c_pkg::OUT_W-1:0]   pos_x,
  output logic signed [s2c_pkg::OUT_W-1:0]   pos_y,
  output logic signed [s2c_pkg::OUT_W-1:0]   pos_z
);
  import s2c_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic signed [CW-1:0] neg(input logic signed [CW-1:0] v);
    return -v;
  endfunction

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [64:0] p);
    logic signed [64:0] s;
    logic signed [28:0] v;
    logic signed [OUT_W-1:0] o;
    s = p + (65'sd1 <<< 35);
    v = $signed(s[64:36]);
    if (v > 29'(OUT_MAX)) begin
      o = OUT_MAX;
    end else if (v < 29'(OUT_MIN)) begin
      o = OUT_MIN;
    end else begin
      o = v[OUT_W-1:0];
    end
    return o;
  endfunction

  logic                   vld_m_r, vld_p_r, vld_f_r, vld_o_r;
  logic signed [CW-1:0]   cp_nxt, sp_nxt, ct_nxt, st_nxt;
  logic signed [CW-1:0]   cp_r, sp_r, ct_r, st_r;
  logic [SCL_W-1:0]       scale_r;
  logic signed [63:0]     mx, my;
  logic signed [63:0]     rx, ry;
  logic signed [CW-1:0]   px_r, py_r, ctp_r;
  logic [CW-1:0]          amp_r;
  logic signed [64:0]     fx_nxt, fy_nxt, fz_nxt;
  logic signed [64:0]     fx_r, fy_r, fz_r;
  logic signed [OUT_W-1:0] pos_x_r, pos_y_r, pos_z_r;

  always_comb begin
    unique case (beat_in.qa)
      QUAD_0: begin cp_nxt = beat_in.ra.x;      sp_nxt = beat_in.ra.y;      end
      QUAD_1: begin cp_nxt = neg(beat_in.ra.y); sp_nxt = beat_in.ra.x;      end
      QUAD_2: begin cp_nxt = neg(beat_in.ra.x); sp_nxt = neg(beat_in.ra.y); end
      default: begin cp_nxt = beat_in.ra.y;     sp_nxt = neg(beat_in.ra.x); end
    endcase
    unique case (beat_in.qp)
      QUAD_0: begin ct_nxt = beat_in.rp.x;      st_nxt = beat_in.rp.y;      end
      QUAD_1: begin ct_nxt = neg(beat_in.rp.y); st_nxt = beat_in.rp.x;      end
      QUAD_2: begin ct_nxt = neg(beat_in.rp.x); st_nxt = neg(beat_in.rp.y); end
      default: begin ct_nxt = beat_in.rp.y;     st_nxt = neg(beat_in.rp.x); end
    endcase
  end

  assign mx = st_r * cp_r;
  assign my = st_r * sp_r;
  assign rx = mx + (64'sd1 <<< 29);
  assign ry = my + (64'sd1 <<< 29);

  assign fx_nxt = $signed({1'b0, amp_r}) * px_r;
  assign fy_nxt = $signed({1'b0, amp_r}) * py_r;
  assign fz_nxt = $signed({1'b0, amp_r}) * ctp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_p_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_o_r <= 1'b0;
    end else begin
      vld_m_r <= beat_in.vld;
      vld_p_r <= vld_m_r;
      vld_f_r <= vld_p_r;
      vld_o_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    cp_r    <= cp_nxt;
    sp_r    <= sp_nxt;
    ct_r    <= ct_nxt;
    st_r    <= st_nxt;
    scale_r <= beat_in.scale;
    px_r    <= rx[61:30];
    py_r    <= ry[61:30];
    ctp_r   <= ct_r;
    amp_r   <= radius * scale_r;
    fx_r    <= fx_nxt;
    fy_r    <= fy_nxt;
    fz_r    <= fz_nxt;
    pos_x_r <= finish(fx_r);
    pos_y_r <= finish(fy_r);
    pos_z_r <= finish(fz_r);
  end

  assign strobe = vld_o_r;
  assign pos_x  = pos_x_r;
  assign pos_y  = pos_y_r;
  assign pos_z  = pos_z_r;

endmodule
`default_nettype wire

// ----- sv/spherical_to_cartesian_top.sv -----
// Channel  | Ports                                        | Handshake
// input    | in_azimuth, in_polar, in_radius_scale        | start && !busy
// result   | out_pos_x, out_pos_y, out_pos_z              | out_strobe, one cycle
// config   | cfg_wdata                                    | cfg_we
//
// One beat enters every cycle; busy is high only while reset is held.
// The pipeline runs phase reduction, one CORDIC cell per stage, quadrant map,
// angle product, radius product, round and saturate.
// Reset is synchronous and clears the valid chain and sets the radius to 1000.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none
module spherical_to_cartesian_top #(
  parameter int CORDIC_STAGES = s2c_pkg::S2C_STAGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [s2c_pkg::ANG_W-1:0]   in_azimuth,
  input  logic signed [s2c_pkg::ANG_W-1:0]   in_polar,
  input  logic [s2c_pkg::SCL_W-1:0]          in_radius_scale,
  output logic                               out_strobe,
  output logic signed [s2c_pkg::OUT_W-1:0]   out_pos_x,
  output logic signed [s2c_pkg::OUT_W-1:0]   out_pos_y,
  output logic signed [s2c_pkg::OUT_W-1:0]   out_pos_z,
  input  logic                               cfg_we,
  input  logic [s2c_pkg::RAD_W-1:0]          cfg_wdata
);
  import s2c_pkg::*;

  logic [RAD_W-1:0]     radius_r;
  logic                 vld0_r;
  logic [SCL_W-1:0]     scale0_r;
  quad_t                qa0, qp0;
  logic signed [CW-1:0] ra0, rp0;
  beat_t                chain [0:CORDIC_STAGES];

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      vld0_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      vld0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    scale0_r <= in_radius_scale;
  end

  s2c_phase u_phase_a (
    .clk   (clk),
    .angle (in_azimuth),
    .quad  (qa0),
    .resid (ra0)
  );

  s2c_phase u_phase_p (
    .clk   (clk),
    .angle (in_polar),
    .quad  (qp0),
    .resid (rp0)
  );

  always_comb begin
    chain[0].vld   = vld0_r;
    chain[0].qa    = qa0;
    chain[0].qp    = qp0;
    chain[0].scale = scale0_r;
    chain[0].ra.x  = CORDIC_GAIN;
    chain[0].ra.y  = '0;
    chain[0].ra.z  = ra0;
    chain[0].rp.x  = CORDIC_GAIN;
    chain[0].rp.y  = '0;
    chain[0].rp.z  = rp0;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    s2c_cell #(
      .STAGE (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  s2c_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_in (chain[CORDIC_STAGES]),
    .radius  (radius_r),
    .strobe  (out_strobe),
    .pos_x   (out_pos_x),
    .pos_y   (out_pos_y),
    .pos_z   (out_pos_z)
  );

endmodule
`default_nettype wire

// ----- sv/s2c_check.sv -----
`default_nettype none
module s2c_check #(
  parameter int CORDIC_STAGES = s2c_pkg::S2C_STAGES
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [s2c_pkg::SCL_W-1:0]          in_radius_scale,
  input logic                               out_strobe,
  input logic signed [s2c_pkg::OUT_W-1:0]   out_pos_x,
  input logic signed [s2c_pkg::OUT_W-1:0]   out_pos_y,
  input logic signed [s2c_pkg::OUT_W-1:0]   out_pos_z
);
  import s2c_pkg::*;

  localparam int LAT = CORDIC_STAGES + 5;

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_strobe)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_radius_scale == '0 |-> ##LAT
      (out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0))
    else $error("zero radius scale gave nonzero position");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

bind spherical_to_cartesian_top s2c_check #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_s2c_check (.*);
`default_nettype wire

// ----- sim/spherical_to_cartesian_top_test.sv -----
`default_nettype none
module spherical_to_cartesian_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import s2c_pkg::*;

  localparam int STAGES = S2C_STAGES;
  localparam int LATENCY = STAGES + 5;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam longint PHASE_STEP = 64'sd10937044409;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint OUT_HI = 64'sd67108863;
  localparam longint OUT_LO = -64'sd67108864;
  localparam longint ARC_STEP [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } pos_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [ANG_W-1:0]  in_azimuth = '0;
  logic signed [ANG_W-1:0]  in_polar = '0;
  logic [SCL_W-1:0]         in_radius_scale = '0;
  logic                     out_strobe;
  logic signed [OUT_W-1:0]  out_pos_x;
  logic signed [OUT_W-1:0]  out_pos_y;
  logic signed [OUT_W-1:0]  out_pos_z;
  logic                     cfg_we = 1'b0;
  logic [RAD_W-1:0]         cfg_wdata = '0;

  pos_t          pending_pos [$];
  logic [RAD_W-1:0] radius_now = RAD_W'(1000);
  bit            idle_on = 1'b1;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;

  spherical_to_cartesian_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_azimuth      (in_azimuth),
    .in_polar        (in_polar),
    .in_radius_scale (in_radius_scale),
    .out_strobe      (out_strobe),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void phase_sin_cos(input logic signed [ANG_W-1:0] ang,
                                        output longint sn, output longint cs);
    longint x, y, z, dx, dy, t;
    logic [31:0] ph, resid;
    quad_t quad;
    ph = 32'((longint'(ang) * PHASE_STEP) >>> 16);
    quad = quad_t'(2'((ph + 32'h2000_0000) >> 30));
    resid = ph - (32'(quad) << 30);
    z = longint'($signed(resid));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t = (i < 24) ? ARC_STEP[i] : 64'sd0;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= t;
      end else begin
        x += dx;
        y -= dy;
        z += t;
      end
    end
    case (quad)
      QUAD_0: begin cs = x;  sn = y;  end
      QUAD_1: begin cs = -y; sn = x;  end
      QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] round_sat(input longint prod);
    longint v;
    v = (prod + (64'sd1 <<< 35)) >>> 36;
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[OUT_W-1:0];
  endfunction

  function automatic pos_t predict_position(input logic signed [ANG_W-1:0] az,
                                            input logic signed [ANG_W-1:0] pol,
                                            input logic [SCL_W-1:0] scl,
                                            input logic [RAD_W-1:0] radius);
    longint sa, ca, st, ct, amp, px, py;
    pos_t p;
    phase_sin_cos(az, sa, ca);
    phase_sin_cos(pol, st, ct);
    amp = longint'(radius) * longint'(scl);
    px = (st * ca + (64'sd1 <<< 29)) >>> 30;
    py = (st * sa + (64'sd1 <<< 29)) >>> 30;
    p.x = round_sat(amp * px);
    p.y = round_sat(amp * py);
    p.z = round_sat(amp * ct);
    return p;
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h4000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s at %0t: got %0d, expected %0d", field, $time, got, want);
  endtask

  task automatic send_beat(input logic signed [ANG_W-1:0] az,
                           input logic signed [ANG_W-1:0] pol,
                           input logic [SCL_W-1:0] scl);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_azimuth <= az;
    in_polar <= pol;
    in_radius_scale <= scl;
    do @(posedge clk); while (busy);
    pending_pos.push_back(predict_position(az, pol, scl, radius_now));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] r);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_now = r;
  endtask

  task automatic test_reset_radius();
    send_beat(0, 0, 16384);
    send_beat(0, 6434, 16384);
    send_beat(6434, 6434, 16384);
    send_beat(12868, 12868, 16384);
    send_beat(-12868, -6434, 16384);
    send_beat(32767, 32767, 65535);
    send_beat(-32768, -32768, 65535);
    send_beat(3217, 3217, 16384);
    send_beat(-3217, 25736, 16384);
    send_beat(1, -1, 1);
    send_beat(-1, 1, 0);
    send_beat(25736, -25736, 32768);
  endtask

  task automatic test_radius_extremes();
    write_radius(16'd0);
    send_beat(6434, 3217, 65535);
    send_beat(0, 0, 65535);
    write_radius(16'hffff);
    send_beat(0, 0, 65535);
    send_beat(0, 12868, 65535);
    send_beat(32767, 6434, 65535);
    send_beat(-32768, -6434, 65535);
    send_beat(9651, -19302, 0);
  endtask

  task automatic test_random_sweep();
    logic [RAD_W-1:0] r;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: r = 16'hffff;
        2: r = 16'd0;
        5: r = 16'd1;
        default: r = RAD_W'($urandom_range(0, 65535));
      endcase
      write_radius(r);
      idle_on = (ph != 3);
      repeat (250) send_beat(pick_field(), pick_field(), pick_field());
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    pos_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_pos.size() == 0) begin
        report_mismatch("unexpected beat pos_x", out_pos_x, 0);
      end else begin
        want = pending_pos.pop_front();
        if (out_pos_x !== want.x) report_mismatch("pos_x", out_pos_x, want.x);
        if (out_pos_y !== want.y) report_mismatch("pos_y", out_pos_y, want.y);
        if (out_pos_z !== want.z) report_mismatch("pos_z", out_pos_z, want.z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_radius();
    test_radius_extremes();
    test_random_sweep();
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && pending_pos.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
